>>> design/bls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants of the bounded lifo stack.
// ----------------------------------------------------------------------------
package bls_pkg;

    // built depth of the entry store
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int CAP_W  = 5;
    localparam int STAT_W = 2;

    // stream widths, padded to whole bytes
    localparam int IN_W   = CMD_W + WORD_W + POS_W;
    localparam int OUT_W  = WORD_W + STAT_W + 2;
    localparam int IN_BW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_BW = ((OUT_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_TOP    = 3'd3,
        CMD_BOTTOM = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS    = 2'd3
    } t_status;

    // decoded command, one per accepted transfer
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic              err;
        logic [CNT_W-1:0]  count_nxt;
        logic              is_empty;
        logic              is_full;
    } t_dec;

endpackage

>>> design/bounded_lifo_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Ram-backed lifo stack with a programmable capacity, one result per command.
// ----------------------------------------------------------------------------
//  channel   direction  fields (lsb first)
//  s         in         cmd[2:0], push_value[34:3], position[39:35]
//  m         out        data[31:0], status[33:32], is_empty[34], is_full[35]
//  cfg       in         capacity[4:0]
//
//  A command is decoded and the ram written or read at the accepting edge;
//  its result enters the output register when the read stage advances.
//  Throughput is one command per cycle while the output is taken.
//  A stalled output holds one command in the read stage and blocks the input.
//  Reset clears the count and sets the capacity to 16; the ram is not cleared.
// ----------------------------------------------------------------------------
module bounded_lifo_stack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // cmd, push_value, position
    input  logic [bls_pkg::IN_BW-1:0]    i_s_tdata,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // data, status, is_empty, is_full, zero padding
    output logic [bls_pkg::OUT_BW-1:0]   o_m_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_we,
    input  logic [bls_pkg::CAP_W-1:0]    i_cfg_wdata
);
    import bls_pkg::*;

    logic [CMD_W-1:0]  in_cmd;
    logic [WORD_W-1:0] in_value;
    logic [POS_W-1:0]  in_pos;

    logic [CAP_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic              r_busy;
    logic              n_busy;
    t_dec              r_pend;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [OUT_BW-1:0] r_out_data;
    logic [OUT_BW-1:0] n_out_data;

    t_dec              dec;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] res_data;
    logic              s_xfer;
    logic              advance;

    // input field unpacking
    assign in_cmd   = i_s_tdata[CMD_W-1:0];
    assign in_value = i_s_tdata[CMD_W+WORD_W-1:CMD_W];
    assign in_pos   = i_s_tdata[IN_W-1:CMD_W+WORD_W];

    // handshake
    assign advance    = r_busy && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_busy || advance;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    bls_decode u_decode (
        .i_cmd      (in_cmd),
        .i_position (in_pos),
        .i_count    (r_count),
        .i_capacity (r_cap),
        .o_dec      (dec)
    );

    bls_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_xfer && dec.wr_en),
        .i_waddr (dec.addr),
        .i_wdata (in_value),
        .i_re    (s_xfer && dec.rd_en),
        .i_raddr (dec.addr),
        .o_rdata (rdata)
    );

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // count, updated on every accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (s_xfer) begin
            r_count <= dec.count_nxt;
        end
    end

    // read stage occupancy
    always_comb begin
        n_busy = r_busy;
        if (s_xfer) begin
            n_busy = 1'b1;
        end else if (advance) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // pending command info, payload only
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_pend <= dec;
        end
    end

    // result word
    always_comb begin
        if (r_pend.err) begin
            res_data = '1;
        end else if (r_pend.rd_en) begin
            res_data = rdata;
        end else begin
            res_data = '0;
        end
        n_out_data = OUT_BW'({r_pend.is_full, r_pend.is_empty, r_pend.status, res_data});
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> design/bls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_ram
// Single-port-write, single-port-read synchronous ram, registered read.
// ----------------------------------------------------------------------------
module bls_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bls_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bls_decode
// Command decode: checks bounds, picks the ram address and the next count.
// ----------------------------------------------------------------------------
module bls_decode (
    input  logic [bls_pkg::CMD_W-1:0] i_cmd,
    input  logic [bls_pkg::POS_W-1:0] i_position,
    input  logic [bls_pkg::CNT_W-1:0] i_count,
    input  logic [bls_pkg::CAP_W-1:0] i_capacity,
    output bls_pkg::t_dec             o_dec
);
    import bls_pkg::*;

    logic [31:0]       cap_eff;
    logic [31:0]       cnt;
    logic [31:0]       pos;
    logic [CNT_W-1:0]  cnt_nxt;

    // capacity saturated into 1..DEPTH
    always_comb begin
        cap_eff = 32'(i_capacity);
        if (cap_eff == 32'd0) begin
            cap_eff = 32'd1;
        end else if (cap_eff > 32'(DEPTH)) begin
            cap_eff = 32'(DEPTH);
        end
    end

    assign cnt = 32'(i_count);
    assign pos = 32'(i_position);

    // per-command checks and ram access
    always_comb begin
        o_dec.wr_en  = 1'b0;
        o_dec.rd_en  = 1'b0;
        o_dec.addr   = '0;
        o_dec.status = ST_OK;
        o_dec.err    = 1'b0;
        cnt_nxt      = i_count;
        unique case (i_cmd)
            CMD_PUSH: begin
                if (cnt >= cap_eff) begin
                    o_dec.status = ST_OVERFLOW;
                    o_dec.err    = 1'b1;
                end else begin
                    o_dec.wr_en = 1'b1;
                    o_dec.addr  = ADDR_W'(cnt);
                    cnt_nxt     = CNT_W'(cnt + 32'd1);
                end
            end
            CMD_POP: begin
                if (cnt == 32'd0) begin
                    o_dec.status = ST_UNDERFLOW;
                    o_dec.err    = 1'b1;
                end else begin
                    o_dec.rd_en = 1'b1;
                    o_dec.addr  = ADDR_W'(cnt - 32'd1);
                    cnt_nxt     = CNT_W'(cnt - 32'd1);
                end
            end
            CMD_PEEK: begin
                if (pos == 32'd0 || pos > cnt) begin
                    o_dec.status = ST_BADPOS;
                    o_dec.err    = 1'b1;
                end else begin
                    o_dec.rd_en = 1'b1;
                    o_dec.addr  = ADDR_W'(cnt - pos);
                end
            end
            CMD_TOP, CMD_BOTTOM: begin
                if (cnt == 32'd0) begin
                    o_dec.status = ST_UNDERFLOW;
                    o_dec.err    = 1'b1;
                end else begin
                    o_dec.rd_en = 1'b1;
                    o_dec.addr  = (i_cmd == CMD_TOP) ? ADDR_W'(cnt - 32'd1) : '0;
                end
            end
            default: begin
                // reserved codes leave the stack alone
            end
        endcase

        // flags after this command
        o_dec.count_nxt = cnt_nxt;
        o_dec.is_empty  = (cnt_nxt == '0);
        o_dec.is_full   = (32'(cnt_nxt) >= cap_eff);
    end

endmodule

>>> dv/bounded_lifo_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack_test
// Self-checking bench for the bounded lifo stack: commands are streamed in
// with random gaps and output back-pressure, a cycle-free stack model works
// out the reply to every accepted command, and replies are compared field by
// field in order. The capacity register is reprogrammed between phases.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_test;
    import bls_pkg::*;

    localparam int                HALF_PERIOD = 2;
    localparam int                RESET_CYCLES = 12;
    localparam int                STUCK_LIMIT = 2000;
    localparam int                RAND_PER_PHASE = 85;
    localparam logic [WORD_W-1:0] ERR_WORD = '1;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  pos;
    } stack_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        t_status           status;
        logic              is_empty;
        logic              is_full;
    } stack_reply_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic [IN_BW-1:0]   i_s_tdata = '0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [OUT_BW-1:0]  o_m_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CAP_W-1:0]   i_cfg_wdata = CAP_RESET;

    // shadow of the stack contents and capacity
    logic [WORD_W-1:0]  shadow_mem [DEPTH];
    int                 shadow_count = 0;
    logic [CAP_W-1:0]   shadow_cap = CAP_RESET;

    stack_cmd_t         pending_cmds [$];
    stack_reply_t       owed_replies [$];
    stack_cmd_t         cmd_on_bus;
    int                 src_gap = 0;
    int                 src_quiet = 0;
    int                 sink_gap = 0;
    int                 sink_quiet = 0;
    int                 stuck_cycles = 0;
    int                 fault_count = 0;

    bounded_lifo_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // apply one command to the shadow stack and return the reply it owes
    function automatic stack_reply_t lifo_apply(stack_cmd_t c);
        stack_reply_t r;
        int           lim;
        lim = (shadow_cap < 1) ? 1 : (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
        r.data = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_PUSH: begin
                if (shadow_count >= lim) begin
                    r.status = ST_OVERFLOW;
                    r.data = ERR_WORD;
                end else begin
                    shadow_mem[shadow_count] = c.value;
                    shadow_count++;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                    r.data = ERR_WORD;
                end else begin
                    shadow_count--;
                    r.data = shadow_mem[shadow_count];
                end
            end
            CMD_PEEK: begin
                if (c.pos == 0 || int'(c.pos) > shadow_count) begin
                    r.status = ST_BADPOS;
                    r.data = ERR_WORD;
                end else begin
                    r.data = shadow_mem[shadow_count - int'(c.pos)];
                end
            end
            CMD_TOP, CMD_BOTTOM: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                    r.data = ERR_WORD;
                end else if (c.cmd == CMD_TOP) begin
                    r.data = shadow_mem[shadow_count - 1];
                end else begin
                    r.data = shadow_mem[0];
                end
            end
            // reserved codes leave the stack alone
            default: ;
        endcase
        r.is_empty = (shadow_count == 0);
        r.is_full = (shadow_count >= lim);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // command source
    always @(posedge i_clk) begin
        stack_cmd_t item;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                owed_replies.push_back(lifo_apply(cmd_on_bus));
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    item = pending_cmds.pop_front();
                    cmd_on_bus <= item;
                    i_s_tdata <= IN_BW'({item.pos, item.value, item.cmd});
                    i_s_tvalid <= 1'b1;
                    if (src_quiet > 0) begin
                        src_quiet <= src_quiet - 1;
                    end else begin
                        if ($urandom_range(0, 39) == 0)
                            src_quiet <= $urandom_range(30, 120);
                        src_gap <= idle_len();
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply sink and checker
    always @(posedge i_clk) begin
        stack_reply_t seen;
        stack_reply_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                seen.data = o_m_tdata[WORD_W-1:0];
                seen.status = t_status'(o_m_tdata[WORD_W +: STAT_W]);
                seen.is_empty = o_m_tdata[WORD_W + STAT_W];
                seen.is_full = o_m_tdata[WORD_W + STAT_W + 1];
                if (owed_replies.size() == 0) begin
                    $error("reply with nothing outstanding: data %0h status %0d",
                           seen.data, seen.status);
                    fault_count++;
                end else begin
                    want = owed_replies.pop_front();
                    if (seen.data !== want.data) begin
                        $error("data: expected %0h, actual %0h", want.data, seen.data);
                        fault_count++;
                    end
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, seen.status);
                        fault_count++;
                    end
                    if (seen.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0b, actual %0b",
                               want.is_empty, seen.is_empty);
                        fault_count++;
                    end
                    if (seen.is_full !== want.is_full) begin
                        $error("is_full: expected %0b, actual %0b", want.is_full, seen.is_full);
                        fault_count++;
                    end
                end
            end
            // back-pressure with quiet stretches
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (sink_quiet > 0)
                    sink_quiet <= sink_quiet - 1;
                else if ($urandom_range(0, 59) == 0)
                    sink_quiet <= $urandom_range(30, 120);
                else if ($urandom_range(0, 3) == 0)
                    sink_gap <= idle_len();
            end
        end
    end

    // watchdog on stalled progress while work is outstanding
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (pending_cmds.size() == 0 && !i_s_tvalid && owed_replies.size() == 0)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] value,
                           input logic [POS_W-1:0] pos);
        stack_cmd_t c;
        c.cmd = cmd;
        c.value = value;
        c.pos = pos;
        pending_cmds.push_back(c);
    endtask

    // random commands, push share steers the stack towards full or empty
    task automatic add_random(input int n, input int push_pct);
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  pos;
        int                r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                cmd = CMD_W'($urandom_range(5, 7));
            end else if (r < 3 + push_pct) begin
                cmd = CMD_PUSH;
            end else begin
                case ($urandom_range(0, 4))
                    0: cmd = CMD_POP;
                    1, 2: cmd = CMD_PEEK;
                    3: cmd = CMD_TOP;
                    default: cmd = CMD_BOTTOM;
                endcase
            end
            case ($urandom_range(0, 11))
                0: value = WORD_MIN;
                1: value = WORD_MAX;
                2: value = '0;
                3: value = '1;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 31));
            else
                pos = POS_W'($urandom_range(0, 17));
            add_cmd(cmd, value, pos);
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || i_s_tvalid || owed_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        shadow_cap = cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        logic [CAP_W-1:0] caps [10];
        caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd20, 5'd5, 5'd16};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack, field extremes, every command and the reserved codes
        add_cmd(CMD_POP, '1, '0);
        add_cmd(CMD_TOP, WORD_MAX, '1);
        add_cmd(CMD_BOTTOM, WORD_MIN, '0);
        add_cmd(CMD_PEEK, '0, 5'd0);
        add_cmd(CMD_PEEK, '0, 5'd1);
        add_cmd(CMD_PUSH, WORD_MIN, '1);
        add_cmd(CMD_PUSH, WORD_MAX, '0);
        add_cmd(CMD_PUSH, '0, 5'd16);
        add_cmd(CMD_PUSH, '1, 5'd31);
        add_cmd(CMD_PEEK, '1, 5'd0);
        add_cmd(CMD_PEEK, '0, 5'd1);
        add_cmd(CMD_PEEK, '0, 5'd4);
        add_cmd(CMD_PEEK, '0, 5'd5);
        add_cmd(CMD_PEEK, '0, 5'd31);
        add_cmd(CMD_TOP, '0, '0);
        add_cmd(CMD_BOTTOM, '0, '0);
        add_cmd(CMD_W'(5), '1, '1);
        add_cmd(CMD_W'(6), '0, '0);
        add_cmd(CMD_W'(7), '1, '1);
        add_cmd(CMD_POP, '0, '0);
        add_cmd(CMD_POP, '0, '0);
        add_cmd(CMD_POP, '0, '0);
        add_cmd(CMD_POP, '0, '0);
        add_cmd(CMD_POP, '0, '0);
        wait_idle();

        // random phases across capacities, including a drop below the count
        for (int p = 0; p < 10; p++) begin
            write_capacity(caps[p]);
            add_random(RAND_PER_PHASE, (p % 2 == 0) ? 65 : 30);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (owed_replies.size() != 0) begin
            $error("%0d replies never arrived", owed_replies.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
design/bls_pkg.sv
design/bls_ram.sv
design/bls_decode.sv
design/bounded_lifo_stack.sv
dv/bounded_lifo_stack_test.sv
